FILE: rtl/bmm_pkg.sv
// Shared types and constants of the banked memory map.
`default_nettype none

package bmm_pkg;

    typedef enum logic [2:0] {
        OP_BANKED_READ  = 3'd0,
        OP_BANKED_WRITE = 3'd1,
        OP_VIDEO_FETCH  = 3'd2,
        OP_RAW_READ     = 3'd3,
        OP_RAW_WRITE    = 3'd4,
        OP_ROM_LOAD     = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        RG_RAM    = 3'd0,
        RG_BASIC  = 3'd1,
        RG_KERNAL = 3'd2,
        RG_CHAR   = 3'd3,
        RG_IO     = 3'd4,
        RG_PORT   = 3'd5
    } t_region;

    typedef enum logic [1:0] {
        LOAD_KERNAL = 2'd0,
        LOAD_BASIC  = 2'd1,
        LOAD_CHAR   = 2'd2
    } t_rom;

    // Where the result byte comes from once the memories have answered.
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_RAM,
        SRC_KERNAL,
        SRC_BASIC,
        SRC_CHAR,
        SRC_PORT
    } t_src;

    localparam logic [15:0] PORT_DIR_ADDR   = 16'h0000;
    localparam logic [15:0] PORT_DATA_ADDR  = 16'h0001;
    localparam logic [15:0] BASIC_BASE      = 16'hA000;
    localparam logic [15:0] BASIC_TOP_SLOT  = 16'hB000;
    localparam logic [15:0] IO_CHAR_BASE    = 16'hD000;
    localparam logic [15:0] KERNAL_BASE     = 16'hE000;
    localparam logic [15:0] VID_CHAR_WINDOW = 16'h1000;

    typedef struct packed {
        logic        ram_we;
        logic [15:0] ram_addr;
        logic        kernal_we;
        logic        basic_we;
        logic        char_we;
        logic [12:0] rom_addr;
        logic [7:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] ram;
        logic [7:0] kernal;
        logic [7:0] basic;
        logic [7:0] chr;
    } t_mem_rd;

endpackage

`default_nettype wire

FILE: rtl/banked_memory_map.sv
// Top level of the banked memory map: port registers, address decode and result stage.
//
//  Channel  | Direction | Word contents
//  s_axis   | in        | opcode, address, write_data, video_bank, rom_select
//  m_axis   | out       | read_data in tdata, region in tuser
//
// Each word is accepted only while no read is in flight: the accept cycle issues
// the memory access, and the next cycle takes the registered read data into the
// output register, since the memories register their read data.
// After reset the RAM is cleared in a sweep over all 65536 bytes; no word is
// accepted until it ends. A stalled output word stays in the output
// register, and a new word is accepted in the cycle that it is taken.
`default_nettype none

module banked_memory_map (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode[2:0], address[18:3], write_data[26:19], video_bank[28:27],
    // rom_select[30:29], zero[31]
    input  wire  [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // region[2:0]
    output logic [2:0]  o_m_axis_tuser
);

    bmm_pkg::t_op     w_op;
    logic [15:0]      w_addr;
    logic [7:0]       w_wdata;
    logic [1:0]       w_vbank;
    bmm_pkg::t_rom    w_rsel;
    logic             w_accept;
    logic             w_mem_ready;
    logic [7:0]       w_lines;
    logic [3:0]       w_slot;
    logic             w_loram;
    logic             w_hiram;
    logic             w_charen;

    bmm_pkg::t_mem_req w_req;
    bmm_pkg::t_mem_rd  w_rd;

    logic             r_busy;
    bmm_pkg::t_src    r_src;
    bmm_pkg::t_src    n_src;
    bmm_pkg::t_region r_region;
    bmm_pkg::t_region n_region;
    logic [7:0]       r_port_data;
    logic [7:0]       n_port_data;
    logic [7:0]       r_port_dir;
    logic [7:0]       r_port_latch;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    bmm_pkg::t_region r_out_region;
    logic [7:0]       n_out_data;

    assign w_op    = bmm_pkg::t_op'(i_s_axis_tdata[2:0]);
    assign w_addr  = i_s_axis_tdata[18:3];
    assign w_wdata = i_s_axis_tdata[26:19];
    assign w_vbank = i_s_axis_tdata[28:27];
    assign w_rsel  = bmm_pkg::t_rom'(i_s_axis_tdata[30:29]);

    assign o_s_axis_tready = w_mem_ready && !r_busy && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Input lines read as 1; output lines read back the latch.
    assign w_lines  = (r_port_latch & r_port_dir) | ~r_port_dir;
    assign w_loram  = w_lines[0];
    assign w_hiram  = w_lines[1];
    assign w_charen = w_lines[2];
    assign w_slot   = w_addr[15:12];

    always_comb begin
        w_req          = '0;
        w_req.ram_addr = w_addr;
        w_req.rom_addr = w_addr[12:0];
        w_req.wdata    = w_wdata;
        n_src          = bmm_pkg::SRC_ZERO;
        n_region       = bmm_pkg::RG_RAM;
        n_port_data    = w_lines;
        case (w_op)
            bmm_pkg::OP_BANKED_READ: begin
                if (w_addr == bmm_pkg::PORT_DIR_ADDR) begin
                    n_src       = bmm_pkg::SRC_PORT;
                    n_region    = bmm_pkg::RG_PORT;
                    n_port_data = r_port_dir;
                end else if (w_addr == bmm_pkg::PORT_DATA_ADDR) begin
                    n_src    = bmm_pkg::SRC_PORT;
                    n_region = bmm_pkg::RG_PORT;
                end else if (w_slot inside {bmm_pkg::BASIC_BASE[15:12],
                                            bmm_pkg::BASIC_TOP_SLOT[15:12]}) begin
                    if (w_loram && w_hiram) begin
                        n_src    = bmm_pkg::SRC_BASIC;
                        n_region = bmm_pkg::RG_BASIC;
                    end else begin
                        n_src = bmm_pkg::SRC_RAM;
                    end
                end else if (w_slot == bmm_pkg::IO_CHAR_BASE[15:12]) begin
                    if (w_charen && (w_loram || w_hiram)) begin
                        // The I/O window answers with the RAM byte beneath.
                        n_src    = bmm_pkg::SRC_RAM;
                        n_region = bmm_pkg::RG_IO;
                    end else if (w_hiram) begin
                        n_src    = bmm_pkg::SRC_CHAR;
                        n_region = bmm_pkg::RG_CHAR;
                    end else begin
                        n_src = bmm_pkg::SRC_RAM;
                    end
                end else if (w_slot >= bmm_pkg::KERNAL_BASE[15:12] && w_hiram) begin
                    n_src    = bmm_pkg::SRC_KERNAL;
                    n_region = bmm_pkg::RG_KERNAL;
                end else begin
                    n_src = bmm_pkg::SRC_RAM;
                end
            end
            bmm_pkg::OP_BANKED_WRITE: begin
                w_req.ram_we = w_accept && (w_addr != bmm_pkg::PORT_DIR_ADDR)
                               && (w_addr != bmm_pkg::PORT_DATA_ADDR);
            end
            bmm_pkg::OP_VIDEO_FETCH: begin
                w_req.ram_addr = {w_vbank, w_addr[13:0]};
                if (w_addr[13:12] == bmm_pkg::VID_CHAR_WINDOW[13:12] && !w_vbank[0]) begin
                    n_src    = bmm_pkg::SRC_CHAR;
                    n_region = bmm_pkg::RG_CHAR;
                end else begin
                    n_src = bmm_pkg::SRC_RAM;
                end
            end
            bmm_pkg::OP_RAW_READ: begin
                n_src = bmm_pkg::SRC_RAM;
            end
            bmm_pkg::OP_RAW_WRITE: begin
                w_req.ram_we = w_accept;
            end
            bmm_pkg::OP_ROM_LOAD: begin
                w_req.kernal_we = w_accept && (w_rsel == bmm_pkg::LOAD_KERNAL);
                w_req.basic_we  = w_accept && (w_rsel == bmm_pkg::LOAD_BASIC);
                w_req.char_we   = w_accept && (w_rsel == bmm_pkg::LOAD_CHAR);
            end
            default: begin
            end
        endcase
    end

    bmm_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rd    (w_rd),
        .o_ready (w_mem_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_dir   <= '0;
            r_port_latch <= '0;
        end else if (w_accept && w_op == bmm_pkg::OP_BANKED_WRITE) begin
            if (w_addr == bmm_pkg::PORT_DIR_ADDR) begin
                r_port_dir <= w_wdata;
            end else if (w_addr == bmm_pkg::PORT_DATA_ADDR) begin
                r_port_latch <= w_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_accept;
        end
        if (w_accept) begin
            r_src       <= n_src;
            r_region    <= n_region;
            r_port_data <= n_port_data;
        end
    end

    always_comb begin
        case (r_src)
            bmm_pkg::SRC_RAM:    n_out_data = w_rd.ram;
            bmm_pkg::SRC_KERNAL: n_out_data = w_rd.kernal;
            bmm_pkg::SRC_BASIC:  n_out_data = w_rd.basic;
            bmm_pkg::SRC_CHAR:   n_out_data = w_rd.chr;
            bmm_pkg::SRC_PORT:   n_out_data = r_port_data;
            default:             n_out_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_busy) begin
            r_out_data   <= n_out_data;
            r_out_region <= r_region;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_region;

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mem_ready |-> !o_s_axis_tready)
        else $error("word accepted during the RAM clearing sweep");

    a_result_follows_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_m_axis_tvalid)
        else $error("accepted word produced no result");

    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_accept)
        else $error("second word accepted while a read is in flight");

    a_ram_write_needs_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.ram_we || w_req.kernal_we || w_req.basic_we || w_req.char_we) |-> w_accept)
        else $error("memory write without an accepted word");
`endif

endmodule

`default_nettype wire

FILE: rtl/bmm_mem.sv
// RAM and ROM arrays of the memory map, with the RAM clearing sweep after reset.
`default_nettype none

module bmm_mem (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bmm_pkg::t_mem_req i_req,
    output bmm_pkg::t_mem_rd  o_rd,
    output logic              o_ready
);

    logic [7:0] ram_mem    [0:65535];
    logic [7:0] kernal_mem [0:8191];
    logic [7:0] basic_mem  [0:8191];
    logic [7:0] char_mem   [0:4095];

    logic        r_clearing;
    logic [15:0] r_clr_addr;

    logic        w_ram_we;
    logic [15:0] w_ram_addr;
    logic [7:0]  w_ram_wdata;

    logic [7:0]  r_ram_q;
    logic [7:0]  r_kernal_q;
    logic [7:0]  r_basic_q;
    logic [7:0]  r_char_q;

    // The sweep owns the RAM port until every byte has been zeroed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 16'd1;
            if (r_clr_addr == 16'hFFFF) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign w_ram_we    = r_clearing | i_req.ram_we;
    assign w_ram_addr  = r_clearing ? r_clr_addr : i_req.ram_addr;
    assign w_ram_wdata = r_clearing ? 8'h00 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (w_ram_we) begin
            ram_mem[w_ram_addr] <= w_ram_wdata;
        end
        r_ram_q <= ram_mem[w_ram_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.kernal_we) begin
            kernal_mem[i_req.rom_addr] <= i_req.wdata;
        end
        r_kernal_q <= kernal_mem[i_req.rom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.basic_we) begin
            basic_mem[i_req.rom_addr] <= i_req.wdata;
        end
        r_basic_q <= basic_mem[i_req.rom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.char_we) begin
            char_mem[i_req.rom_addr[11:0]] <= i_req.wdata;
        end
        r_char_q <= char_mem[i_req.rom_addr[11:0]];
    end

    assign o_rd.ram    = r_ram_q;
    assign o_rd.kernal = r_kernal_q;
    assign o_rd.basic  = r_basic_q;
    assign o_rd.chr    = r_char_q;

    assign o_ready = !r_clearing;

endmodule

`default_nettype wire

FILE: dv/banked_memory_map_tb.sv
// Self-checking testbench for the banked memory map: random and directed accesses.
`default_nettype none

module banked_memory_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned RESET_CYCLES = 12;
    // The RAM clearing sweep after reset accepts nothing until every byte is zeroed.
    localparam int unsigned STALL_LIMIT  = 300_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // Opcodes and ROM selects that the block must ignore.
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;
    localparam logic [1:0] LOAD_NONE      = 2'd3;

    typedef struct packed {
        logic [7:0]       data;
        bmm_pkg::t_region region;
    } t_reply;

    class access_scoreboard;
        bit [7:0]    ram [65536];
        bit [7:0]    kernal [8192];
        bit [7:0]    basic [8192];
        bit [7:0]    chr [4096];
        bit          kernal_set [8192];
        bit          basic_set [8192];
        bit          chr_set [4096];
        bit [7:0]    dir;
        bit [7:0]    latch;
        t_reply      replies_due [$];
        int unsigned errors;

        // Works out the reply to one access word from the current state, without changing it.
        function void decode_access(input logic [31:0] w, output t_reply r, output bit rom_hit,
                                    output bmm_pkg::t_rom rom, output logic [12:0] off);
            logic [2:0]  op;
            logic [15:0] a;
            logic [1:0]  vb;
            logic [2:0]  lines;
            logic [13:0] vlocal;
            op      = w[2:0];
            a       = w[18:3];
            vb      = w[28:27];
            lines   = (latch[2:0] & dir[2:0]) | ~dir[2:0];
            r.data  = 8'h00;
            r.region = bmm_pkg::RG_RAM;
            rom_hit = 1'b0;
            rom     = bmm_pkg::LOAD_KERNAL;
            off     = '0;
            case (op)
                bmm_pkg::OP_BANKED_READ: begin
                    if (a == bmm_pkg::PORT_DIR_ADDR) begin
                        r.data   = dir;
                        r.region = bmm_pkg::RG_PORT;
                    end else if (a == bmm_pkg::PORT_DATA_ADDR) begin
                        r.data   = (latch & dir) | ~dir;
                        r.region = bmm_pkg::RG_PORT;
                    end else if (a[15:13] == bmm_pkg::BASIC_BASE[15:13] && lines[0]
                                 && lines[1]) begin
                        r.region = bmm_pkg::RG_BASIC;
                        rom_hit  = 1'b1;
                        rom      = bmm_pkg::LOAD_BASIC;
                        off      = a[12:0];
                        r.data   = basic[off];
                    end else if (a[15:12] == bmm_pkg::IO_CHAR_BASE[15:12] && lines[2]
                                 && (lines[0] || lines[1])) begin
                        // The I/O window shows the RAM byte underneath.
                        r.region = bmm_pkg::RG_IO;
                        r.data   = ram[a];
                    end else if (a[15:12] == bmm_pkg::IO_CHAR_BASE[15:12] && lines[1]) begin
                        r.region = bmm_pkg::RG_CHAR;
                        rom_hit  = 1'b1;
                        rom      = bmm_pkg::LOAD_CHAR;
                        off      = {1'b0, a[11:0]};
                        r.data   = chr[off[11:0]];
                    end else if (a >= bmm_pkg::KERNAL_BASE && lines[1]) begin
                        r.region = bmm_pkg::RG_KERNAL;
                        rom_hit  = 1'b1;
                        rom      = bmm_pkg::LOAD_KERNAL;
                        off      = a[12:0];
                        r.data   = kernal[off];
                    end else begin
                        r.data = ram[a];
                    end
                end
                bmm_pkg::OP_VIDEO_FETCH: begin
                    vlocal = a[13:0];
                    if (vlocal[13:12] == bmm_pkg::VID_CHAR_WINDOW[13:12] && !vb[0]) begin
                        r.region = bmm_pkg::RG_CHAR;
                        rom_hit  = 1'b1;
                        rom      = bmm_pkg::LOAD_CHAR;
                        off      = {1'b0, vlocal[11:0]};
                        r.data   = chr[off[11:0]];
                    end else begin
                        r.data = ram[{vb, vlocal}];
                    end
                end
                bmm_pkg::OP_RAW_READ: r.data = ram[a];
                default: ;
            endcase
        endfunction

        function bit unloaded_rom(input logic [31:0] w, output bmm_pkg::t_rom rom,
                                  output logic [12:0] off);
            t_reply r;
            bit     hit;
            decode_access(w, r, hit, rom, off);
            if (!hit)
                return 1'b0;
            case (rom)
                bmm_pkg::LOAD_KERNAL: return !kernal_set[off];
                bmm_pkg::LOAD_BASIC:  return !basic_set[off];
                default:              return !chr_set[off[11:0]];
            endcase
        endfunction

        function void note_access(input logic [31:0] w);
            t_reply        r;
            bit            hit;
            bmm_pkg::t_rom rom;
            logic [12:0]   off;
            logic [15:0]   a;
            logic [7:0]    wd;
            decode_access(w, r, hit, rom, off);
            replies_due.push_back(r);
            a  = w[18:3];
            wd = w[26:19];
            case (w[2:0])
                bmm_pkg::OP_BANKED_WRITE: begin
                    if (a == bmm_pkg::PORT_DIR_ADDR)
                        dir = wd;
                    else if (a == bmm_pkg::PORT_DATA_ADDR)
                        latch = wd;
                    else
                        ram[a] = wd;
                end
                bmm_pkg::OP_RAW_WRITE: ram[a] = wd;
                bmm_pkg::OP_ROM_LOAD: begin
                    case (w[30:29])
                        bmm_pkg::LOAD_KERNAL: begin
                            kernal[a[12:0]]     = wd;
                            kernal_set[a[12:0]] = 1'b1;
                        end
                        bmm_pkg::LOAD_BASIC: begin
                            basic[a[12:0]]     = wd;
                            basic_set[a[12:0]] = 1'b1;
                        end
                        bmm_pkg::LOAD_CHAR: begin
                            chr[a[11:0]]     = wd;
                            chr_set[a[11:0]] = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void check_reply(input logic [7:0] data, input logic [2:0] region);
            t_reply r;
            if (replies_due.size() == 0) begin
                $error("unexpected word: read_data %02h, region %0d", data, region);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (data !== r.data) begin
                $error("read_data: expected %02h, got %02h", r.data, data);
                errors++;
            end
            if (region !== r.region) begin
                $error("region: expected %0d, got %0d", r.region, region);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [7:0]  o_m_axis_tdata;
    wire  [2:0]  o_m_axis_tuser;

    access_scoreboard sb = new();
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      idle_pct = 20;
    int unsigned      idle_count = 0;

    banked_memory_map i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && m_tready)
            sb.check_reply(o_m_axis_tdata, o_m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : sink
        int unsigned span;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 12);
                repeat (span) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [31:0] pack(input logic [2:0] op, input logic [15:0] addr,
                                         input logic [7:0] wd, input logic [1:0] vb,
                                         input logic [1:0] rs);
        return {1'b0, rs, vb, wd, addr, op};
    endfunction

    // Called at a falling edge; returns at a falling edge after the word is taken.
    task automatic send(input logic [31:0] w);
        int unsigned span;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_access(w);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            span = $urandom_range(1, 12);
            repeat (span) @(negedge i_clk);
        end
    endtask

    // A read of a ROM byte that was never loaded is outside the contract, so load it first.
    task automatic issue(input logic [31:0] w);
        bmm_pkg::t_rom rom;
        logic [12:0]   off;
        logic [15:0]   la;
        if (sb.unloaded_rom(w, rom, off)) begin
            la = 16'($urandom);
            if (rom == bmm_pkg::LOAD_CHAR)
                la[11:0] = off[11:0];
            else
                la[12:0] = off;
            send(pack(bmm_pkg::OP_ROM_LOAD, la, 8'($urandom), 2'($urandom), rom));
        end
        send(w);
    endtask

    initial begin : stimulus
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  dir;
        int unsigned pick;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Port registers straight out of reset, then ROM loads with wrapping offsets.
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'h0000, 8'hFF, 2'd3, LOAD_NONE));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'h0001, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_RAW_READ, 16'hFFFF, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_ROM_LOAD, 16'hFFFF, 8'hFF, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_ROM_LOAD, 16'h2000, 8'h81, 2'd3, bmm_pkg::LOAD_BASIC));
        issue(pack(bmm_pkg::OP_ROM_LOAD, 16'hF000, 8'h3C, 2'd0, bmm_pkg::LOAD_CHAR));
        issue(pack(bmm_pkg::OP_ROM_LOAD, 16'h0005, 8'hAA, 2'd0, LOAD_NONE));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'hFFFF, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'hA000, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_RAW_WRITE, 16'hD000, 8'h5A, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'hD000, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        // CHAREN low with all three lines driven: the character ROM shows at $D000.
        issue(pack(bmm_pkg::OP_BANKED_WRITE, 16'h0000, 8'h07, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_WRITE, 16'h0001, 8'h03, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'hD000, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'h0000, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'h0001, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        // All lines low: every slot reads RAM, apart from the two port registers.
        issue(pack(bmm_pkg::OP_BANKED_WRITE, 16'h0001, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_READ, 16'hFFFF, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_VIDEO_FETCH, 16'h1000, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_VIDEO_FETCH, 16'h1000, 8'h00, 2'd1, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_VIDEO_FETCH, 16'hFFFF, 8'h00, 2'd3, bmm_pkg::LOAD_KERNAL));
        issue(pack(OP_RESERVED_LO, 16'h1234, 8'hFF, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(OP_RESERVED_HI, 16'h1234, 8'hFF, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_BANKED_WRITE, 16'h1234, 8'hC3, 2'd0, bmm_pkg::LOAD_KERNAL));
        issue(pack(bmm_pkg::OP_RAW_READ, 16'h1234, 8'h00, 2'd0, bmm_pkg::LOAD_KERNAL));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0)
                idle_pct = (n / 100) % 3 == 0 ? 0 : ((n / 100) % 3 == 1 ? 15 : 40);
            if (n == 300)
                hold_req = 1'b1;
            if (n == 600) begin
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end
            if (n == RANDOM_ITEMS - 150)
                quiet = 1'b1;

            // Each stretch starts from a fresh banking setup on the processor port.
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: dir = 8'hFF;
                    1: dir = 8'h07;
                    2: dir = 8'h00;
                    default: dir = 8'($urandom);
                endcase
                issue(pack(bmm_pkg::OP_BANKED_WRITE, bmm_pkg::PORT_DIR_ADDR, dir,
                           2'($urandom), 2'($urandom)));
                issue(pack(bmm_pkg::OP_BANKED_WRITE, bmm_pkg::PORT_DATA_ADDR, 8'($urandom),
                           2'($urandom), 2'($urandom)));
            end

            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = bmm_pkg::OP_BANKED_READ;
            else if (pick < 45)
                op = bmm_pkg::OP_BANKED_WRITE;
            else if (pick < 60)
                op = bmm_pkg::OP_VIDEO_FETCH;
            else if (pick < 70)
                op = bmm_pkg::OP_RAW_READ;
            else if (pick < 80)
                op = bmm_pkg::OP_RAW_WRITE;
            else if (pick < 96)
                op = bmm_pkg::OP_ROM_LOAD;
            else
                op = $urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO;

            // Mostly a small set of offsets in every slot, so writes are read back.
            case ($urandom_range(0, 9))
                0: addr = 16'($urandom);
                1: addr = 16'($urandom_range(0, 1));
                default: addr = {4'($urandom), 7'd0, 5'($urandom)};
            endcase
            issue(pack(op, addr, 8'($urandom), 2'($urandom), 2'($urandom)));
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
